FILE: rtl/strarm_pkg.sv
`default_nettype none
package strarm_pkg;

  localparam int LEAVES     = 1024;
  localparam int LOG_LEAVES = $clog2(LEAVES);
  localparam int NODES      = 2 * LEAVES - 1;
  localparam int NODE_W     = $clog2(NODES);
  localparam int DEPTH_W    = $clog2(LOG_LEAVES + 1);
  localparam int FRAME_W    = (LOG_LEAVES > 1) ? $clog2(LOG_LEAVES) : 1;
  localparam int RANGE_W    = 11;
  localparam int POS_W      = (LOG_LEAVES + 1 > RANGE_W) ? LOG_LEAVES + 1 : RANGE_W;
  localparam int DATA_W     = 64;
  localparam int CFG_W      = 63;

  localparam logic [CFG_W-1:0] EMPTY_RESET = 63'd1000000000000000;

  localparam logic [1:0] FN_ADD  = 2'd0;
  localparam logic [1:0] FN_MIN  = 2'd1;
  localparam logic [1:0] FN_LOAD = 2'd2;
  localparam logic [1:0] FN_NOP  = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] pend;
    logic [DATA_W-1:0] smin;
  } node_t;

  typedef struct packed {
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    node_t             wr_data;
    logic [NODE_W-1:0] rd_addr;
  } ram_req_t;

endpackage
`default_nettype wire

FILE: rtl/strarm_node_ram.sv
`default_nettype none
module strarm_node_ram (
  input  wire                    clk,
  input  strarm_pkg::ram_req_t   req,
  output strarm_pkg::node_t      rd_data
);

  strarm_pkg::node_t mem [strarm_pkg::NODES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/segment_tree_range_add_range_min.sv
`default_nettype none
// Walk: after acceptance a node inside or outside the range passes S_VISIT, S_LEAF and S_RET
//   (a query skips S_LEAF at a node outside it), a split node is merged in S_COMB; a range visits
//   up to about 4 nodes per level, a load walks 21 nodes, and a query presents min_value from S_OUT.
// Throughput: one transaction at a time; in_ready stays low for the whole walk.
// Reset: synchronous, active high; then a clearing pass over all 2*LEAVES-1 nodes (2047)
//   zeroes the node memory while in_ready stays low. Config writes are taken always.
module segment_tree_range_add_range_min (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [1:0]                          func,
  input  wire  [strarm_pkg::RANGE_W-1:0]      range_low,
  input  wire  [strarm_pkg::RANGE_W-1:0]      range_high,
  input  wire  [9:0]                          leaf_index,
  input  wire  signed [strarm_pkg::DATA_W-1:0] value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [strarm_pkg::DATA_W-1:0] min_value,
  input  wire                                 cfg_we,
  input  wire  [strarm_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int NW = strarm_pkg::NODE_W;
  localparam int DW = strarm_pkg::DEPTH_W;
  localparam int PW = strarm_pkg::POS_W;
  localparam int VW = strarm_pkg::DATA_W;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_VISIT = 3'd2;
  localparam logic [2:0] S_LEAF  = 3'd3;
  localparam logic [2:0] S_RET   = 3'd4;
  localparam logic [2:0] S_COMB  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]                  state;
  logic [NW-1:0]               clr_addr;
  logic [NW-1:0]               node;
  logic [DW-1:0]               depth;
  logic [PW-1:0]               lo;
  logic [PW-1:0]               rng_l;
  logic [PW-1:0]               rng_h;
  logic [1:0]                  func_q;
  logic [VW-1:0]               val_q;
  logic                        cov_q;
  logic                        rflag;
  logic [VW-1:0]               rval;
  logic [VW-1:0]               mval;
  logic [VW-1:0]               res_q;
  logic [strarm_pkg::CFG_W-1:0] empty_result;

  // One frame per tree level: the left child's answer waits here for the right one.
  logic                        frame_flag [strarm_pkg::LOG_LEAVES];
  logic [VW-1:0]               frame_val  [strarm_pkg::LOG_LEAVES];

  strarm_pkg::ram_req_t        req;
  strarm_pkg::node_t           rd_data;

  strarm_node_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // Span and overlap of the current node against the requested range
  logic [PW-1:0]   span;
  logic [PW-1:0]   hi;
  logic            no_ovl;
  logic            covered;
  logic [DW-1:0]   dm1;
  logic [strarm_pkg::FRAME_W-1:0] fidx;
  logic [NW-1:0]   parent;
  logic            fa;
  logic [VW-1:0]   fa_val;
  logic            comb_found;
  logic [VW-1:0]   comb_min;
  logic [VW-1:0]   leaf_sm;
  logic [VW-1:0]   leaf_pa;
  logic [VW-1:0]   comb_res;
  logic            in_empty;
  logic [PW-1:0]   in_l;
  logic [PW-1:0]   in_h;

  assign span     = {{(PW-1){1'b0}}, 1'b1} << (DW'(strarm_pkg::LOG_LEAVES) - depth);
  assign hi       = lo + span;
  assign no_ovl   = (lo >= rng_h) || (rng_l >= hi);
  assign covered  = (lo >= rng_l) && (hi <= rng_h);
  assign dm1      = depth - {{(DW-1){1'b0}}, 1'b1};
  assign fidx     = dm1[strarm_pkg::FRAME_W-1:0];
  assign parent   = (node - {{(NW-1){1'b0}}, 1'b1}) >> 1;
  assign fa       = frame_flag[fidx];
  assign fa_val   = frame_val[fidx];

  // Combine left and right answers; a side outside the range takes no part.
  always_comb begin
    comb_found = fa | rflag;
    if (fa && rflag) begin
      comb_min = ($signed(fa_val) < $signed(rval)) ? fa_val : rval;
    end else if (fa) begin
      comb_min = fa_val;
    end else begin
      comb_min = rval;
    end
  end

  // Update of a covered node: add goes to both fields, load replaces the minimum only.
  assign leaf_sm  = (func_q == strarm_pkg::FN_ADD) ? rd_data.smin + val_q : val_q;
  assign leaf_pa  = (func_q == strarm_pkg::FN_ADD) ? rd_data.pend + val_q : rd_data.pend;
  assign comb_res = mval + rd_data.pend;

  // Decode the incoming transaction; a load becomes the one-position range.
  always_comb begin
    in_l = PW'(range_low);
    in_h = PW'(range_high);
    in_empty = (in_l >= in_h) || (in_l >= PW'(strarm_pkg::LEAVES));
    if (func == strarm_pkg::FN_LOAD) begin
      in_l = PW'(leaf_index);
      in_h = PW'(leaf_index) + {{(PW-1){1'b0}}, 1'b1};
      in_empty = (in_l >= PW'(strarm_pkg::LEAVES));
    end
  end

  assign in_ready = (state == S_IDLE);

  // Memory requests
  always_comb begin
    req.wr_en   = 1'b0;
    req.wr_addr = node;
    req.wr_data = '0;
    req.rd_addr = node;
    case (state)
      S_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = clr_addr;
      end
      S_LEAF: begin
        req.wr_en        = cov_q && (func_q != strarm_pkg::FN_MIN);
        req.wr_data.pend = leaf_pa;
        req.wr_data.smin = leaf_sm;
      end
      S_RET: begin
        req.rd_addr = parent;
      end
      S_COMB: begin
        req.wr_en        = (func_q != strarm_pkg::FN_MIN);
        req.wr_data.pend = rd_data.pend;
        req.wr_data.smin = comb_res;
      end
      default: begin
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_result <= strarm_pkg::EMPTY_RESET;
    end else if (cfg_we) begin
      empty_result <= cfg_wdata;
    end
  end

  // Frame stack
  always_ff @(posedge clk) begin
    if (state == S_RET && depth != '0 && node[0]) begin
      frame_flag[fidx] <= rflag;
      frame_val[fidx]  <= rval;
    end
  end

  // Traversal sequencer: depth-first walk with an explicit per-level frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + {{(NW-1){1'b0}}, 1'b1};
          if (clr_addr == NW'(strarm_pkg::NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            rng_l  <= in_l;
            rng_h  <= in_h;
            val_q  <= value;
            node   <= '0;
            depth  <= '0;
            lo     <= '0;
            if (func == strarm_pkg::FN_MIN && in_empty) begin
              res_q <= {1'b0, empty_result};
              state <= S_OUT;
            end else if (!in_empty && func != strarm_pkg::FN_NOP) begin
              state <= S_VISIT;
            end
          end
        end
        S_VISIT: begin
          if (no_ovl) begin
            cov_q <= 1'b0;
            if (func_q == strarm_pkg::FN_MIN) begin
              rflag <= 1'b0;
              state <= S_RET;
            end else begin
              state <= S_LEAF;
            end
          end else if (covered) begin
            cov_q <= 1'b1;
            state <= S_LEAF;
          end else begin
            node  <= {node[NW-2:0], 1'b1};
            depth <= depth + {{(DW-1){1'b0}}, 1'b1};
          end
        end
        S_LEAF: begin
          rflag <= 1'b1;
          if (cov_q && func_q != strarm_pkg::FN_MIN) begin
            rval <= leaf_sm;
          end else begin
            rval <= rd_data.smin;
          end
          state <= S_RET;
        end
        S_RET: begin
          if (depth == '0) begin
            if (func_q == strarm_pkg::FN_MIN) begin
              res_q <= rflag ? rval : {1'b0, empty_result};
              state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end else if (node[0]) begin
            // left child done: advance to its sibling
            node  <= node + {{(NW-1){1'b0}}, 1'b1};
            lo    <= lo + span;
            state <= S_VISIT;
          end else begin
            // right child done: climb to the parent
            node  <= parent;
            depth <= dm1;
            lo    <= lo - span;
            if (comb_found) begin
              mval  <= comb_min;
              state <= S_COMB;
            end else begin
              rflag <= 1'b0;
            end
          end
        end
        S_COMB: begin
          rflag <= 1'b1;
          rval  <= comb_res;
          state <= S_RET;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            min_value <= res_q;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(strarm_pkg::LOG_LEAVES))
    else $error("walk went below the leaves");
  a_out_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (func_q == strarm_pkg::FN_MIN))
    else $error("result produced for a non-query");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
